// ===== rtl/core/cart_position_pi_with_swingup_reference_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cart position controller
// Concurrent check shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef CART_POSITION_PI_WITH_SWINGUP_REFERENCE_TOP_ASSERT_SVH
`define CART_POSITION_PI_WITH_SWINGUP_REFERENCE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpsr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpsr: next-cycle check failed");

`endif

// ===== rtl/core/cpsr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpsr_pkg
// Types, constants and the microprogram of the cart position controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpsr_pkg;

  // Stream payload widths
  localparam int unsigned InW      = 48;
  localparam int unsigned OutW     = 48;
  localparam int unsigned EncW     = 32;
  localparam int unsigned AdcW     = 12;
  localparam int unsigned DutyW    = 7;
  localparam int unsigned DirW     = 2;
  localparam int unsigned DacW     = 12;
  localparam int unsigned EffW     = 19;

  // Result field positions inside the output tdata
  localparam int unsigned OutDutyLsb   = 0;
  localparam int unsigned OutDirLsb    = 7;
  localparam int unsigned OutDacLsb    = 9;
  localparam int unsigned OutSwingLsb  = 21;
  localparam int unsigned OutEffortLsb = 22;

  // Configuration port
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_NOW       = 4'd0,
    CFG_GAIN_BEFORE    = 4'd1,
    CFG_EFFORT_LIMIT   = 4'd2,
    CFG_REFERENCE_LOW  = 4'd3,
    CFG_REFERENCE_HIGH = 4'd4,
    CFG_DWELL_TICKS    = 4'd5,
    CFG_CYCLE_TICKS    = 4'd6,
    CFG_BALANCE_WINDOW = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0]        gain_now;
    logic [23:0]        gain_before;
    logic [17:0]        effort_limit;
    logic signed [17:0] reference_low;
    logic signed [17:0] reference_high;
    logic [7:0]         dwell_ticks;
    logic [7:0]         cycle_ticks;
    logic [17:0]        balance_window;
  } cfg_t;

  localparam logic [23:0]        RstGainNow    = 24'd1428685;
  localparam logic [23:0]        RstGainBefore = 24'd1428226;
  localparam logic [17:0]        RstEffortLim  = 18'd176947;
  localparam logic signed [17:0] RstRefLow     = -18'sd3932;
  localparam logic signed [17:0] RstRefHigh    = 18'sd5243;
  localparam logic [7:0]         RstDwell      = 8'd120;
  localparam logic [7:0]         RstCycle      = 8'd240;
  localparam logic [17:0]        RstWindow     = 18'd6554;

  // Bridge direction codes
  typedef enum logic [DirW-1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } drive_dir_e;

  // Scaling constants (Q16.16)
  localparam int unsigned PiQ      = 205973;
  localparam int unsigned AdcGain  = 2 * PiQ;
  localparam int unsigned PosNum   = 4608;
  localparam int unsigned PosDen   = 665;
  localparam int unsigned PosShift = 29;
  localparam int unsigned DacScale = 9100;
  localparam int unsigned DutyScale     = 100;
  localparam int unsigned DutyMax       = 100;
  localparam int unsigned DivThreeRecip = 171;

  // floor(2^29 * 4608 / 665): position = (enc * PosRecip) >> 29, low by at most one
  localparam logic [31:0] PosRecip =
    32'(((64'd1 << PosShift) * PosNum) / PosDen);
  // Smallest encoder count whose position reaches 2^31
  localparam logic [30:0] PosSatEnc =
    31'((((64'd1 << 31) * PosDen) + PosNum - 1) / PosNum);

  // Datapath widths
  localparam int unsigned ProdW = 62;
  localparam int unsigned SumW  = 58;
  localparam int unsigned AccW  = 43;

  // Microprogram
  localparam int unsigned PcW = 4;
  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_POS,
    MUL_QDIV,
    MUL_GNOW,
    MUL_GBEF,
    MUL_DAC
  } mul_sel_e;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_SWING,
    ALU_POS_QUOT,
    ALU_POS_FIX,
    ALU_ERROR,
    ALU_SUM_LOAD,
    ALU_SUM_SUB,
    ALU_EFFORT,
    ALU_DUTY,
    ALU_OUTPUT,
    ALU_SCHED
  } alu_e;

  typedef enum logic [1:0] {
    BR_NONE,
    BR_TICK,
    BR_ALWAYS
  } br_e;

  typedef struct packed {
    mul_sel_e mul;
    alu_e     alu;
    br_e      br;
    pc_t      target;
    logic     last;
  } cw_t;

  typedef struct packed {
    cw_t  cw;
    logic act;
    logic start;
  } ctrl_t;

  localparam pc_t STEP_DISPATCH   = 4'd0;
  localparam pc_t STEP_SWING      = 4'd1;
  localparam pc_t STEP_POS_QUOT   = 4'd2;
  localparam pc_t STEP_POS_MUL    = 4'd3;
  localparam pc_t STEP_POS_FIX    = 4'd4;
  localparam pc_t STEP_ERROR      = 4'd5;
  localparam pc_t STEP_MUL_NOW    = 4'd6;
  localparam pc_t STEP_MUL_BEFORE = 4'd7;
  localparam pc_t STEP_SUM_SUB    = 4'd8;
  localparam pc_t STEP_EFFORT     = 4'd9;
  localparam pc_t STEP_EMIT       = 4'd10;
  localparam pc_t STEP_OUTPUT     = 4'd11;
  localparam pc_t STEP_TICK       = 4'd12;

  function automatic cw_t rom_word(pc_t pc);
    cw_t w;
    w = '{mul: MUL_NONE, alu: ALU_NONE, br: BR_NONE, target: STEP_DISPATCH, last: 1'b0};
    case (pc)
      STEP_DISPATCH: begin
        w.mul    = MUL_POS;
        w.br     = BR_TICK;
        w.target = STEP_TICK;
      end
      STEP_SWING:      w.alu = ALU_SWING;
      STEP_POS_QUOT:   w.alu = ALU_POS_QUOT;
      STEP_POS_MUL:    w.mul = MUL_QDIV;
      STEP_POS_FIX:    w.alu = ALU_POS_FIX;
      STEP_ERROR:      w.alu = ALU_ERROR;
      STEP_MUL_NOW:    w.mul = MUL_GNOW;
      STEP_MUL_BEFORE: begin
        w.mul = MUL_GBEF;
        w.alu = ALU_SUM_LOAD;
      end
      STEP_SUM_SUB:    w.alu = ALU_SUM_SUB;
      STEP_EFFORT:     w.alu = ALU_EFFORT;
      STEP_EMIT: begin
        w.mul = MUL_DAC;
        w.alu = ALU_DUTY;
      end
      STEP_OUTPUT: begin
        w.alu  = ALU_OUTPUT;
        w.last = 1'b1;
      end
      STEP_TICK: begin
        w.alu    = ALU_SCHED;
        w.br     = BR_ALWAYS;
        w.target = STEP_EMIT;
      end
      default:         w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/cpsr_cfg.sv =====
// ----------------------------------------------------------------------------
// cpsr_cfg
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpsr_cfg import cpsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_now       <= RstGainNow;
      cfg_q.gain_before    <= RstGainBefore;
      cfg_q.effort_limit   <= RstEffortLim;
      cfg_q.reference_low  <= RstRefLow;
      cfg_q.reference_high <= RstRefHigh;
      cfg_q.dwell_ticks    <= RstDwell;
      cfg_q.cycle_ticks    <= RstCycle;
      cfg_q.balance_window <= RstWindow;
    end else if (cfg_valid_i) begin
      // Drop writes to unknown indexes
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_NOW:       cfg_q.gain_now       <= cfg_data_i;
        CFG_GAIN_BEFORE:    cfg_q.gain_before    <= cfg_data_i;
        CFG_EFFORT_LIMIT:   cfg_q.effort_limit   <= cfg_data_i[17:0];
        CFG_REFERENCE_LOW:  cfg_q.reference_low  <= signed'(cfg_data_i[17:0]);
        CFG_REFERENCE_HIGH: cfg_q.reference_high <= signed'(cfg_data_i[17:0]);
        CFG_DWELL_TICKS:    cfg_q.dwell_ticks    <= cfg_data_i[7:0];
        CFG_CYCLE_TICKS:    cfg_q.cycle_ticks    <= cfg_data_i[7:0];
        CFG_BALANCE_WINDOW: cfg_q.balance_window <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/cpsr_seq.sv =====
// ----------------------------------------------------------------------------
// cpsr_seq
// Microprogram sequencer: step counter, control ROM and branch logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpsr_seq import cpsr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_op_i,
  output logic  in_ready_o,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_e;

  seq_state_e state_q, state_d;
  pc_t        pc_q, pc_d;
  logic       op_q, op_d;
  cw_t        cw;
  logic       start, act, taken;

  always_comb begin
    cw    = rom_word(pc_q);
    start = (state_q == SEQ_IDLE) && in_valid_i;
    // Hold on the last step while the output register is still occupied
    act   = (state_q == SEQ_RUN) && !(cw.last && !out_free_i);
    case (cw.br)
      BR_TICK:   taken = op_q;
      BR_ALWAYS: taken = 1'b1;
      default:   taken = 1'b0;
    endcase

    state_d = state_q;
    pc_d    = pc_q;
    op_d    = op_q;
    case (state_q)
      SEQ_IDLE: begin
        if (start) begin
          state_d = SEQ_RUN;
          pc_d    = STEP_DISPATCH;
          op_d    = in_op_i;
        end
      end
      SEQ_RUN: begin
        if (act) begin
          if (cw.last) begin
            state_d = SEQ_IDLE;
          end else if (taken) begin
            pc_d = cw.target;
          end else begin
            pc_d = pc_q + pc_t'(1);
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= STEP_DISPATCH;
      op_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      op_q    <= op_d;
    end
  end

  assign in_ready_o   = (state_q == SEQ_IDLE);
  assign ctrl_o.cw    = cw;
  assign ctrl_o.act   = act;
  assign ctrl_o.start = start;

endmodule

// ===== rtl/core/cpsr_dp.sv =====
// ----------------------------------------------------------------------------
// cpsr_dp
// Datapath: shared multiplier, controller state and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpsr_dp import cpsr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_t           ctrl_i,
  input  cfg_t            cfg_i,
  input  logic [EncW-1:0] enc_count_i,
  input  logic [AdcW-1:0] adc_code_i,
  output logic [OutW-1:0] out_data_o
);

  // Input latches and working registers
  logic [EncW-1:0]         enc_q;
  logic [AdcW-1:0]         adc_q;
  logic signed [ProdW-1:0] prod_q;
  logic [30:0]             quot_q;
  logic signed [31:0]      err_q;
  logic signed [SumW-1:0]  sum_q;
  logic [DutyW-1:0]        duty_q;
  logic [OutW-1:0]         out_q;

  // Controller state
  logic [30:0]             pos_q;
  logic signed [31:0]      eprev_q;
  logic signed [EffW-1:0]  effort_q;
  logic signed [17:0]      ref_q;
  logic [7:0]              phase_q;
  logic                    swing_q;

  // Multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.cw.mul)
      MUL_POS: begin
        mul_a = {4'b0, enc_q[28:0]};
        mul_b = {1'b0, PosRecip};
      end
      MUL_QDIV: begin
        mul_a = {2'b0, quot_q};
        mul_b = 33'(PosDen);
      end
      MUL_GNOW: begin
        mul_a = {9'b0, cfg_i.gain_now};
        mul_b = {err_q[31], err_q};
      end
      MUL_GBEF: begin
        mul_a = {9'b0, cfg_i.gain_before};
        mul_b = {eprev_q[31], eprev_q};
      end
      MUL_DAC: begin
        mul_a = {2'b0, pos_q};
        mul_b = 33'(DacScale);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Angle window: compare adc*2*PI against the window edges times 4095
  logic [30:0] adc_scaled, win_hi, win_lo;
  logic [18:0] hi_n;
  logic [19:0] lo_n;
  logic        lo_pos, swing_next;

  always_comb begin
    adc_scaled = 31'(adc_q) * 31'(AdcGain);
    hi_n       = 19'(cfg_i.balance_window) + 19'(PiQ);
    win_hi     = {hi_n, 12'b0} - 31'(hi_n);
    lo_n       = 20'(PiQ + 1) - 20'(cfg_i.balance_window);
    lo_pos     = !lo_n[19] && (lo_n != '0);
    win_lo     = 31'({lo_n[17:0], 12'b0}) - 31'(lo_n[17:0]);
    swing_next = !((adc_scaled < win_hi) && (!lo_pos || (adc_scaled >= win_lo)));
  end

  // Position: correct the reciprocal quotient by one, clamp negative and huge counts
  logic [41:0] enc_x, rem;
  logic [30:0] pos_next;

  always_comb begin
    enc_x = 42'({enc_q[28:0], 12'b0}) + 42'({enc_q[28:0], 9'b0});
    rem   = enc_x - prod_q[41:0];
    if (enc_q[31]) begin
      pos_next = '0;
    end else if (enc_q[30:0] >= PosSatEnc) begin
      pos_next = '1;
    end else begin
      pos_next = quot_q + 31'(rem >= 42'(PosDen));
    end
  end

  // Error, saturated at the negative end only
  logic [32:0] diff;
  logic [31:0] err_next;

  always_comb begin
    diff     = {{15{ref_q[17]}}, ref_q} - {2'b0, pos_q};
    err_next = (diff[32] && !diff[31]) ? 32'h8000_0000 : diff[31:0];
  end

  // Effort update and clamp
  logic signed [AccW-1:0] acc, lim_s, lim_neg;
  logic signed [EffW-1:0] eff_next;

  always_comb begin
    acc     = AccW'(effort_q) + AccW'(signed'(sum_q[SumW-1:16]));
    lim_s   = AccW'(cfg_i.effort_limit);
    lim_neg = -lim_s;
    if (acc > lim_s) begin
      eff_next = lim_s[EffW-1:0];
    end else if (acc < lim_neg) begin
      eff_next = lim_neg[EffW-1:0];
    end else begin
      eff_next = acc[EffW-1:0];
    end
  end

  // Duty: floor(floor(|effort|*100/65536)/3), capped
  logic [EffW-1:0]  mag;
  logic [24:0]      scaled;
  logic [8:0]       duty_t;
  logic [16:0]      third;
  logic [DutyW-1:0] duty_next;

  always_comb begin
    mag       = effort_q[EffW-1] ? EffW'(-effort_q) : effort_q;
    scaled    = 25'(mag) * 25'(DutyScale);
    duty_t    = scaled[24:16];
    third     = 17'(duty_t) * 17'(DivThreeRecip);
    duty_next = (third[16:9] > 8'(DutyMax)) ? DutyW'(DutyMax) : third[15:9];
  end

  // Result word
  drive_dir_e      dir;
  logic [OutW-1:0] out_d;

  always_comb begin
    if (effort_q == '0) begin
      dir = DIR_OFF;
    end else if (effort_q[EffW-1]) begin
      dir = DIR_REV;
    end else begin
      dir = DIR_FWD;
    end
    out_d = '0;
    out_d[OutDutyLsb +: DutyW]  = duty_q;
    out_d[OutDirLsb +: DirW]    = dir;
    out_d[OutDacLsb +: DacW]    = prod_q[27:16];
    out_d[OutSwingLsb]          = swing_q;
    out_d[OutEffortLsb +: EffW] = effort_q;
  end

  // Swing-up schedule
  logic [8:0] phase_inc;
  assign phase_inc = 9'(phase_q) + 9'd1;

  // Working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      enc_q <= enc_count_i;
      adc_q <= adc_code_i;
    end
    if (ctrl_i.act && (ctrl_i.cw.mul != MUL_NONE)) begin
      prod_q <= mul_p[ProdW-1:0];
    end
    if (ctrl_i.act) begin
      case (ctrl_i.cw.alu)
        ALU_POS_QUOT: quot_q <= prod_q[59:29];
        ALU_ERROR:    err_q  <= signed'(err_next);
        ALU_SUM_LOAD: sum_q  <= prod_q[SumW-1:0];
        ALU_SUM_SUB:  sum_q  <= sum_q - prod_q[SumW-1:0];
        ALU_DUTY:     duty_q <= duty_next;
        ALU_OUTPUT:   out_q  <= out_d;
        default: ;
      endcase
    end
  end

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      eprev_q  <= '0;
      effort_q <= '0;
      ref_q    <= '0;
      phase_q  <= '0;
      swing_q  <= 1'b1;
    end else if (ctrl_i.act) begin
      case (ctrl_i.cw.alu)
        ALU_SWING:   swing_q <= swing_next;
        ALU_POS_FIX: pos_q   <= pos_next;
        ALU_EFFORT: begin
          effort_q <= eff_next;
          eprev_q  <= err_q;
        end
        ALU_SCHED: begin
          if (swing_q) begin
            if (phase_q < cfg_i.dwell_ticks) begin
              ref_q   <= cfg_i.reference_low;
              phase_q <= phase_inc[7:0];
            end else begin
              ref_q   <= cfg_i.reference_high;
              phase_q <= (phase_inc > 9'(cfg_i.cycle_ticks)) ? 8'd0 : phase_inc[7:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/core/cart_position_pi_with_swingup_reference_top.sv =====
// ----------------------------------------------------------------------------
// cart_position_pi_with_swingup_reference_top
// Cart position PI controller for a pendulum rig with a swing-up reference
// schedule. A sample transaction (tuser = 0) carries the encoder count and
// the angle ADC code; the block scales them to Q16.16 position and angle,
// sets the swing-up flag when the angle leaves the balance window, runs one
// incremental PI step on the position error, clamps the effort to the
// configured bound and returns PWM duty, bridge direction, a 12-bit DAC
// position code, the swing flag and the effort. A tick transaction
// (tuser = 1) advances the swing-up reference schedule while the swing flag
// is set and returns the held outputs. Every input transaction gives exactly
// one output transaction. A sample or a tick occupies the microprogram
// sequencer for the length of its microprogram, which runs the chain of
// dependent products through one shared 33x33 multiplier. The next item is
// taken in the cycle after the last step, so a new sample or tick is not
// taken before the last one is through. An output result that is not taken
// yet holds the last step of the following item. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cart_position_pi_with_swingup_reference_top import cpsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: [31:0] enc_count (signed), [43:32] adc_code, [47:44] zero
  input  logic [InW-1:0]      s_axis_tdata_i,
  // tuser: [0] op (0 = control sample, 1 = schedule tick)
  input  logic                s_axis_tuser_i,
  // Output stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: [6:0] pwm_duty, [8:7] drive_dir, [20:9] dac_code, [21] swinging,
  //        [40:22] effort (signed), [47:41] zero
  output logic [OutW-1:0]     m_axis_tdata_o,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  m_valid_q, m_valid_d;
  logic  out_free, out_load;

  // Register file: gains, effort bound, schedule references and window
  cpsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer: takes one transaction, then steps through the control ROM.
  // The first step branches to the tick routine when tuser says so.
  cpsr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Datapath: the control word picks the multiplier operands and the
  // register that the step updates; the last step fills the output register.
  cpsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .enc_count_i (s_axis_tdata_i[EncW-1:0]),
    .adc_code_i  (s_axis_tdata_i[EncW +: AdcW]),
    .out_data_o  (m_axis_tdata_o)
  );

  // The output register is free when empty or emptied in this cycle
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign out_load = ctrl.act && ctrl.cw.last;

  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;

endmodule

// ===== rtl/core/cpsr_chk.sv =====
// ----------------------------------------------------------------------------
// cpsr_chk
// Port-level checker for the cart position controller, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cart_position_pi_with_swingup_reference_top_assert.svh"

module cpsr_chk import cpsr_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid_i,
  input logic            s_axis_tready_o,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [OutW-1:0] m_axis_tdata_o
);

  // A stalled result stays offered and unchanged
  `CPSR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `CPSR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))

  // One item at a time: an accepted transaction closes the input side
  `CPSR_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // Bridge off exactly when the effort is zero
  `CPSR_ASSERT_IMPL(a_dir_effort, clk_i, rst_ni, m_axis_tvalid_o, (m_axis_tdata_o[OutDirLsb +: DirW] == DIR_OFF) == (m_axis_tdata_o[OutEffortLsb +: EffW] == '0))

  // Duty never exceeds full scale
  `CPSR_ASSERT_IMPL(a_duty_cap, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[OutDutyLsb +: DutyW] <= DutyW'(DutyMax))

endmodule

bind cart_position_pi_with_swingup_reference_top cpsr_chk u_chk (.*);
